// File: rtl/core/tkrk_pkg.sv
// shared types and constants of the top-k rating keeper
`timescale 1ns / 1ps

package tkrk_pkg;

    // number of cells in the chain
    localparam int CAPACITY = 16;
    // width of the fill counter, holds zero through CAPACITY
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // limit register
    localparam int LIMIT_W = 5;
    localparam logic [LIMIT_W-1:0] MAX_ENTRIES_RESET = 5'd16;

    // one stored entry
    typedef struct packed {
        logic signed [31:0] rating;
        logic        [31:0] item_id;
    } entry_t;

    // operation broadcast to every cell
    typedef struct packed {
        logic do_insert;
        logic do_evict;
    } cell_ctl_t;

endpackage

// File: rtl/core/tkrk_cell.sv
// one cell of the sorted chain: holds an entry, shifts with its neighbors
`timescale 1ns / 1ps

module tkrk_cell
    import tkrk_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  logic      occupied,
    input  entry_t    cand,
    input  entry_t    lower_entry,
    input  logic      lower_le,
    input  entry_t    upper_entry,
    input  logic      upper_le,
    output entry_t    entry,
    output logic      le
);

    entry_t entry_reg;
    entry_t entry_next;

    // held entry rates at or below the candidate
    assign le = occupied && !(entry_reg.rating > cand.rating);

    // shift up on plain insert, shift down on evict-and-insert
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.do_insert)
        begin
            if (!le)
            begin
                if (lower_le)
                begin
                    entry_next = cand;
                end
                else
                begin
                    entry_next = lower_entry;
                end
            end
        end
        else if (ctl.do_evict)
        begin
            if (upper_le)
            begin
                entry_next = upper_entry;
            end
            else if (le)
            begin
                entry_next = cand;
            end
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: rtl/core/top_k_rating_keeper.sv
// top level of the top-k rating keeper: cell chain, fill count and result register
`timescale 1ns / 1ps

// Keeps the highest-rated entries offered so far, sorted ascending by rating,
// up to the limit in max_entries (saturated at CAPACITY).
// Input channel: in_valid/in_ready with rating and item_id. Each transaction
// yields exactly one result on the output channel out_valid/out_ready:
// accepted, evicted with the evicted entry, entry_count and lowest_rating.
// Config channel: cfg_valid/cfg_ready with cfg_data, always ready; write it only
// while no result is pending.
// Latency: the result is valid in the cycle after the input transaction.
// Throughput: one item per cycle; every cell compares its own rating against the
// broadcast candidate and shifts in one step, so the chain length does not add
// cycles. A new item is taken while the held result is being taken in the same
// cycle; when the receiver stalls, in_ready drops and the result holds.
// Reset: fill count clears to empty, limit returns to 16, no result pending.
// The stored entries need no clearing; only occupied cells are ever compared.

module top_k_rating_keeper
    import tkrk_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  rating,
    input  logic        [31:0]  item_id,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                accepted,
    output logic                evicted,
    output logic        [31:0]  evicted_id,
    output logic signed [31:0]  evicted_rating,
    output logic        [4:0]   entry_count,
    output logic signed [31:0]  lowest_rating,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic        [4:0]   cfg_data
);

    logic [LIMIT_W-1:0] max_entries_reg;
    logic [CNT_W-1:0]   fill_count_reg;
    logic [CNT_W-1:0]   fill_count_next;
    logic [CNT_W-1:0]   limit;
    logic               out_valid_reg;
    logic               accepted_reg;
    logic               evicted_reg;
    logic [31:0]        evicted_id_reg;
    logic signed [31:0] evicted_rating_reg;

    logic      in_fire;
    logic      not_full;
    logic      beats_lowest;
    cell_ctl_t ctl;
    entry_t    cand;
    entry_t    cells [CAPACITY];
    logic      cell_le [CAPACITY];

    // handshakes
    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    // limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= MAX_ENTRIES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_entries_reg <= cfg_data;
        end
    end

    // effective limit saturated at capacity
    always_comb
    begin
        if (int'(max_entries_reg) > CAPACITY)
        begin
            limit = CNT_W'(CAPACITY);
        end
        else
        begin
            limit = CNT_W'(max_entries_reg);
        end
    end

    // decide the operation for this transaction
    assign cand.rating   = rating;
    assign cand.item_id  = item_id;
    assign not_full      = fill_count_reg < limit;
    assign beats_lowest  = (fill_count_reg != '0) && (rating > cells[0].rating);
    assign ctl.do_insert = in_fire && not_full;
    assign ctl.do_evict  = in_fire && !not_full && beats_lowest;

    // cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t lower_entry;
        logic   lower_le;
        entry_t upper_entry;
        logic   upper_le;

        if (i == 0)
        begin : g_bottom
            assign lower_entry = '0;
            assign lower_le    = 1'b1;
        end
        else
        begin : g_lower
            assign lower_entry = cells[i-1];
            assign lower_le    = cell_le[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_top
            assign upper_entry = '0;
            assign upper_le    = 1'b0;
        end
        else
        begin : g_upper
            assign upper_entry = cells[i+1];
            assign upper_le    = cell_le[i+1];
        end

        tkrk_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .occupied    (CNT_W'(i) < fill_count_reg),
            .cand        (cand),
            .lower_entry (lower_entry),
            .lower_le    (lower_le),
            .upper_entry (upper_entry),
            .upper_le    (upper_le),
            .entry       (cells[i]),
            .le          (cell_le[i])
        );
    end

    // fill count grows only on plain insert
    assign fill_count_next = ctl.do_insert ? fill_count_reg + 1'b1 : fill_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            accepted_reg       <= ctl.do_insert || ctl.do_evict;
            evicted_reg        <= ctl.do_evict;
            evicted_id_reg     <= ctl.do_evict ? cells[0].item_id : 32'd0;
            evicted_rating_reg <= ctl.do_evict ? cells[0].rating : 32'sd0;
        end
    end

    // outputs; count and lowest follow the store, which changes only with a new result
    assign out_valid      = out_valid_reg;
    assign accepted       = accepted_reg;
    assign evicted        = evicted_reg;
    assign evicted_id     = evicted_id_reg;
    assign evicted_rating = evicted_rating_reg;
    assign entry_count    = 5'(fill_count_reg);
    assign lowest_rating  = (fill_count_reg != '0) ? cells[0].rating : 32'sd0;

    // fill never passes capacity
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_count_reg) <= CAPACITY)
        else $error("fill count above capacity");

    // an eviction always comes with acceptance
    a_evict_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && evicted) |-> accepted)
        else $error("eviction without acceptance");

    // evict-and-insert keeps the fill count
    a_evict_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.do_evict |=> (fill_count_reg == $past(fill_count_reg)))
        else $error("fill count changed on eviction");

    // a result that does not evict reports a zero entry
    a_no_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !evicted) |-> (evicted_id == 32'd0 && evicted_rating == 32'sd0))
        else $error("evicted entry not zero");

endmodule
